// ===== rtl/tcc_pkg.sv =====
package tcc_pkg;

    localparam int CoordW = 18;              // vertex coordinate, signed Q2.16
    localparam int DiffW  = CoordW + 1;      // coordinate difference
    localparam int SqW    = 2 * CoordW;      // square of a coordinate
    localparam int NormW  = SqW + 1;         // squared norm of a vertex
    localparam int AuxW   = NormW + 1;       // difference of squared norms
    localparam int ProdW  = 2 * DiffW;       // product of two differences
    localparam int DetW   = ProdW + 2;       // twice the signed area determinant
    localparam int MulW   = AuxW + DiffW;    // norm difference times edge difference
    localparam int NumW   = MulW + 1;        // numerator of one center coordinate
    localparam int RemW   = NumW + 1;        // rounded dividend 2|n| + |d|
    localparam int DenW   = DetW + 1;        // divisor 2|d|
    localparam int OutW   = 32;              // center coordinate, signed Q15.16
    localparam int CmpW   = DenW + OutW;     // widest shifted divisor

    typedef struct packed {
        logic valid;
        logic deg;
    } t_ctl;

endpackage

// ===== rtl/tcc_front.sv =====
module tcc_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_xa,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_ya,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_xb,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_yb,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_xc,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_yc,
    output tcc_pkg::t_ctl                      o_ctl,
    output logic signed [tcc_pkg::NumW-1:0]    o_num_x,
    output logic signed [tcc_pkg::NumW-1:0]    o_num_y,
    output logic signed [tcc_pkg::DetW-1:0]    o_den_x,
    output logic signed [tcc_pkg::DetW-1:0]    o_den_y
);
    import tcc_pkg::*;

    logic [5:1] r_vld;

    // Stage 1: edge differences and coordinate squares.
    logic signed [DiffW-1:0] r_dyac1, r_dyab1, r_dxab1, r_dxac1;
    logic signed [SqW-1:0]   r_sxa, r_sya, r_sxb, r_syb, r_sxc, r_syc;
    // Stage 2: squared norms and the two determinant products.
    logic signed [DiffW-1:0] r_dyac2, r_dyab2, r_dxab2, r_dxac2;
    logic signed [NormW-1:0] r_na, r_nb, r_nc;
    logic signed [ProdW-1:0] r_p1, r_p2;
    // Stage 3: norm differences and the doubled determinant.
    logic signed [DiffW-1:0] r_dyac3, r_dyab3, r_dxab3, r_dxac3;
    logic signed [AuxW-1:0]  r_aux1, r_aux2;
    logic signed [DetW-1:0]  r_det3;
    // Stage 4: numerator products.
    logic signed [MulW-1:0]  r_m1, r_m2, r_m3, r_m4;
    logic signed [DetW-1:0]  r_det4;
    // Stage 5: numerators, divisors and the collinear flag.
    logic signed [NumW-1:0]  r_nx, r_ny;
    logic signed [DetW-1:0]  r_dx, r_dy;
    logic                    r_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dyac1 <= DiffW'(i_ya) - DiffW'(i_yc);
            r_dyab1 <= DiffW'(i_ya) - DiffW'(i_yb);
            r_dxab1 <= DiffW'(i_xa) - DiffW'(i_xb);
            r_dxac1 <= DiffW'(i_xa) - DiffW'(i_xc);
            r_sxa   <= i_xa * i_xa;
            r_sya   <= i_ya * i_ya;
            r_sxb   <= i_xb * i_xb;
            r_syb   <= i_yb * i_yb;
            r_sxc   <= i_xc * i_xc;
            r_syc   <= i_yc * i_yc;

            r_dyac2 <= r_dyac1;
            r_dyab2 <= r_dyab1;
            r_dxab2 <= r_dxab1;
            r_dxac2 <= r_dxac1;
            r_na    <= NormW'(r_sxa) + NormW'(r_sya);
            r_nb    <= NormW'(r_sxb) + NormW'(r_syb);
            r_nc    <= NormW'(r_sxc) + NormW'(r_syc);
            r_p1    <= r_dyac1 * r_dxab1;
            r_p2    <= r_dyab1 * r_dxac1;

            r_dyac3 <= r_dyac2;
            r_dyab3 <= r_dyab2;
            r_dxab3 <= r_dxab2;
            r_dxac3 <= r_dxac2;
            r_aux1  <= AuxW'(r_na) - AuxW'(r_nb);
            r_aux2  <= AuxW'(r_na) - AuxW'(r_nc);
            r_det3  <= (DetW'(r_p1) - DetW'(r_p2)) <<< 1;

            r_m1    <= r_aux1 * r_dyac3;
            r_m2    <= r_aux2 * r_dyab3;
            r_m3    <= r_aux1 * r_dxac3;
            r_m4    <= r_aux2 * r_dxab3;
            r_det4  <= r_det3;

            r_nx    <= NumW'(r_m1) - NumW'(r_m2);
            r_ny    <= NumW'(r_m3) - NumW'(r_m4);
            r_dx    <= r_det4;
            r_dy    <= -r_det4;
            r_deg   <= (r_det4 == '0);
        end
    end

    assign o_ctl.valid = r_vld[5];
    assign o_ctl.deg   = r_deg;
    assign o_num_x     = r_nx;
    assign o_num_y     = r_ny;
    assign o_den_x     = r_dx;
    assign o_den_y     = r_dy;

endmodule

// ===== rtl/tcc_div.sv =====
module tcc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  tcc_pkg::t_ctl                     i_ctl,
    input  logic signed [tcc_pkg::NumW-1:0]   i_num,
    input  logic signed [tcc_pkg::DetW-1:0]   i_den,
    output tcc_pkg::t_ctl                     o_ctl,
    output logic signed [tcc_pkg::OutW-1:0]   o_quot,
    output logic                              o_sat
);
    import tcc_pkg::*;

    logic [NumW-1:0]  w_an;
    logic [DetW-1:0]  w_ad;

    // Operand stage: magnitudes, result sign, rounding offset.
    t_ctl             r_ctl_a;
    logic             r_neg_a;
    logic [RemW-1:0]  r_n_a;
    logic [DenW-1:0]  r_d_a;

    // Restoring divider: one quotient bit per stage, MSB first.
    t_ctl             r_ctl [0:OutW];
    logic             r_neg [0:OutW];
    logic             r_ovf [0:OutW];
    logic [RemW-1:0]  r_rem [0:OutW];
    logic [DenW-1:0]  r_den [0:OutW];
    logic [OutW-1:0]  r_q   [0:OutW];

    // Output stage.
    t_ctl                    r_ctl_o;
    logic signed [OutW-1:0]  r_quot;
    logic                    r_sat;

    logic [OutW-1:0] w_lim;
    logic            w_clip;

    assign w_an = i_num[NumW-1] ? NumW'(-i_num) : NumW'(i_num);
    assign w_ad = i_den[DetW-1] ? DetW'(-i_den) : DetW'(i_den);

    assign w_lim  = r_neg[OutW] ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
    assign w_clip = r_ovf[OutW] || (r_q[OutW] > w_lim);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl_a.deg <= i_ctl.deg;
            r_neg_a     <= i_num[NumW-1] ^ i_den[DetW-1];
            r_n_a       <= {w_an, 1'b0} + RemW'(w_ad);
            r_d_a       <= {w_ad, 1'b0};

            // A quotient of 2^OutW or more cannot fit and is clipped later.
            r_ctl[0].deg <= r_ctl_a.deg;
            r_neg[0]     <= r_neg_a;
            r_ovf[0]     <= ((CmpW+1)'(r_n_a) >= {1'b0, r_d_a, {OutW{1'b0}}});
            r_rem[0]     <= r_n_a;
            r_den[0]     <= r_d_a;
            r_q[0]       <= '0;

            for (int k = 0; k < OutW; k++) begin
                r_ctl[k+1].deg <= r_ctl[k].deg;
                r_neg[k+1]     <= r_neg[k];
                r_ovf[k+1]     <= r_ovf[k];
                r_den[k+1]     <= r_den[k];
                if (CmpW'(r_rem[k]) >= (CmpW'(r_den[k]) << (OutW-1-k))) begin
                    r_rem[k+1] <= RemW'(CmpW'(r_rem[k]) - (CmpW'(r_den[k]) << (OutW-1-k)));
                    r_q[k+1]   <= r_q[k] | (OutW'(1) << (OutW-1-k));
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_q[k+1]   <= r_q[k];
                end
            end

            r_ctl_o.deg <= r_ctl[OutW].deg;
            r_sat       <= w_clip;
            if (r_neg[OutW]) begin
                r_quot <= w_clip ? -$signed(w_lim) : -$signed(r_q[OutW]);
            end else begin
                r_quot <= w_clip ? $signed(w_lim) : $signed(r_q[OutW]);
            end
        end

        if (!i_rst_n) begin
            r_ctl_a.valid <= 1'b0;
            for (int k = 0; k <= OutW; k++) begin
                r_ctl[k].valid <= 1'b0;
            end
            r_ctl_o.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl_a.valid <= i_ctl.valid;
            r_ctl[0].valid <= r_ctl_a.valid;
            for (int k = 0; k < OutW; k++) begin
                r_ctl[k+1].valid <= r_ctl[k].valid;
            end
            r_ctl_o.valid <= r_ctl[OutW].valid;
        end
    end

    assign o_ctl  = r_ctl_o;
    assign o_quot = r_quot;
    assign o_sat  = r_sat;

endmodule

// ===== rtl/triangle_circumcenter.sv =====
// Channel  | Valid    | Ready    | Payload
// ---------+----------+----------+---------------------------------------------
// vertices | i_valid  | o_ready  | i_vertex_{a,b,c}_{x,y}, signed Q2.16
// center   | o_valid  | i_ready  | o_center_x/y Q15.16, o_degenerate, o_saturated
//
// One triangle is accepted per cycle while o_ready is high. Each passes through
// the multiplies and adds, then through each coordinate's divider, where a
// 32-stage restoring divider produces one quotient bit per stage.
// Reset clears only the valid bits; payload registers are left as they are.
// A stall on the result side freezes the whole pipeline at once, so nothing
// in flight is dropped or repeated, and o_ready falls only while the final
// result register holds a transaction that has not been taken.
module triangle_circumcenter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_vertex_a_x,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_vertex_a_y,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_vertex_b_x,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_vertex_b_y,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_vertex_c_x,
    input  logic signed [tcc_pkg::CoordW-1:0]  i_vertex_c_y,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [tcc_pkg::OutW-1:0]    o_center_x,
    output logic signed [tcc_pkg::OutW-1:0]    o_center_y,
    output logic                               o_degenerate,
    output logic                               o_saturated
);
    import tcc_pkg::*;

    logic                    w_en;
    t_ctl                    w_front_ctl;
    t_ctl                    w_ctl_x;
    t_ctl                    w_ctl_y;
    logic signed [NumW-1:0]  w_num_x, w_num_y;
    logic signed [DetW-1:0]  w_den_x, w_den_y;
    logic signed [OutW-1:0]  w_qx, w_qy;
    logic                    w_sat_x, w_sat_y;

    // The pipeline advances whenever the output register is empty or drained.
    assign w_en    = !w_ctl_x.valid || i_ready;
    assign o_ready = w_en;

    tcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_xa    (i_vertex_a_x),
        .i_ya    (i_vertex_a_y),
        .i_xb    (i_vertex_b_x),
        .i_yb    (i_vertex_b_y),
        .i_xc    (i_vertex_c_x),
        .i_yc    (i_vertex_c_y),
        .o_ctl   (w_front_ctl),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_den_x (w_den_x),
        .o_den_y (w_den_y)
    );

    // Both dividers run in lockstep; the x divider's control copy drives the
    // output handshake and carries the collinear flag.
    tcc_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_front_ctl),
        .i_num   (w_num_x),
        .i_den   (w_den_x),
        .o_ctl   (w_ctl_x),
        .o_quot  (w_qx),
        .o_sat   (w_sat_x)
    );

    tcc_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_front_ctl),
        .i_num   (w_num_y),
        .i_den   (w_den_y),
        .o_ctl   (w_ctl_y),
        .o_quot  (w_qy),
        .o_sat   (w_sat_y)
    );

    // Collinear vertices force a zero center and suppress the clip flag.
    assign o_valid      = w_ctl_x.valid;
    assign o_degenerate = w_ctl_x.deg;
    assign o_center_x   = w_ctl_x.deg ? '0 : w_qx;
    assign o_center_y   = w_ctl_x.deg ? '0 : w_qy;
    assign o_saturated  = !w_ctl_x.deg && (w_sat_x || w_sat_y);

    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl_x.valid == w_ctl_y.valid && w_ctl_x.deg == w_ctl_y.deg)
        else $error("coordinate dividers out of step");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_center_x == {1'b1, {(OutW-1){1'b0}}} ||
            o_center_x == {1'b0, {(OutW-1){1'b1}}} ||
            o_center_y == {1'b1, {(OutW-1){1'b0}}} ||
            o_center_y == {1'b0, {(OutW-1){1'b1}}})
        else $error("saturated flag without a clipped coordinate");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(w_num_x) && $stable(w_den_y))
        else $error("pipeline moved during an output stall");

endmodule

// ===== tb/triangle_circumcenter_test.sv =====
`timescale 1ns / 1ps

// Self-checking test of the triangle circumcenter pipeline.
module triangle_circumcenter_test;

    localparam int CW = tcc_pkg::CoordW;
    localparam int OW = tcc_pkg::OutW;
    localparam int PIPE_LAT = 40;
    localparam int HOLD_CYCLES = 300;

    typedef logic signed [CW-1:0] t_coord;

    // One triangle as driven on the input channel.
    typedef struct packed {
        t_coord ax, ay, bx, by, cx, cy;
    } t_tri;

    // One center as it should appear on the output channel.
    typedef struct packed {
        logic signed [OW-1:0] cx;
        logic signed [OW-1:0] cy;
        logic                 deg;
        logic                 sat;
    } t_center;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    t_coord i_vertex_a_x, i_vertex_a_y, i_vertex_b_x, i_vertex_b_y;
    t_coord i_vertex_c_x, i_vertex_c_y;
    logic signed [OW-1:0] o_center_x, o_center_y;
    logic o_degenerate, o_saturated;

    triangle_circumcenter DUT (.*);

    t_tri    pending_tris[$];
    t_center expected_centers[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  recv_hold     = 0;   // cycles the receiver still holds off
    int  hold_reqs     = 0;   // hold-off requests raised by the stimulus
    int  hold_seen     = 0;   // hold-off requests already started
    int  mismatches    = 0;
    logic o_ready_sampled = 1'b0;

    // Rounded quotient n/d, ties away from zero, clipped to the output range.
    function automatic logic signed [OW-1:0] round_div(input logic signed [127:0] n,
                                                       input logic signed [127:0] d,
                                                       inout logic sat);
        logic [127:0] an, ad, q, lim;
        logic neg;
        neg = n[127] ^ d[127];
        an  = n[127] ? -n : n;
        ad  = d[127] ? -d : d;
        q   = (2 * an + ad) / (2 * ad);
        lim = neg ? (128'd1 << (OW - 1)) : (128'd1 << (OW - 1)) - 1;
        if (q > lim) begin
            sat = 1'b1;
            q   = lim;
        end
        return neg ? -q[OW-1:0] : q[OW-1:0];
    endfunction

    // Closed-form circumcenter with exact 128-bit intermediates.
    function automatic t_center circumcenter(input t_tri t);
        logic signed [127:0] xa, ya, xb, yb, xc, yc, aux1, aux2, det;
        logic signed [127:0] dyac, dyab, dxab, dxac;
        t_center r;
        logic sat;
        xa = t.ax; ya = t.ay; xb = t.bx; yb = t.by; xc = t.cx; yc = t.cy;
        aux1 = (xa * xa + ya * ya) - (xb * xb + yb * yb);
        aux2 = (xa * xa + ya * ya) - (xc * xc + yc * yc);
        dyac = ya - yc; dyab = ya - yb; dxab = xa - xb; dxac = xa - xc;
        det  = 2 * (dyac * dxab - dyab * dxac);
        sat  = 1'b0;
        r    = '0;
        if (det == 0) begin
            r.deg = 1'b1;
            return r;
        end
        r.cx  = round_div(aux1 * dyac - aux2 * dyab, det, sat);
        r.cy  = round_div(aux1 * dxac - aux2 * dxab, -det, sat);
        r.sat = sat;
        return r;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0: return -(1 << (CW - 1));
            1: return (1 << (CW - 1)) - 1;
            2: return int'($urandom_range(0, 64)) - 32;
            default: return int'($signed(t_coord'($urandom)));
        endcase
    endfunction

    task automatic queue_tri(input int ax, ay, bx, by, cx, cy);
        pending_tris.insert(pending_tris.size(),
                            '{t_coord'(ax), t_coord'(ay), t_coord'(bx),
                              t_coord'(by), t_coord'(cx), t_coord'(cy)});
    endtask

    task automatic wait_drained();
        while (pending_tris.size() != 0 || expected_centers.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: presents queued triangles at the falling edge. The prediction is
    // made at acceptance so the expected order always matches the wire order.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            {i_vertex_a_x, i_vertex_a_y, i_vertex_b_x, i_vertex_b_y,
             i_vertex_c_x, i_vertex_c_y} <= '0;
        end else if (!i_valid || o_ready_sampled) begin
            if (pending_tris.size() != 0 &&
                ($urandom_range(0, 99) >= send_idle_pct)) begin
                t_tri t;
                t = pending_tris.pop_front();
                {i_vertex_a_x, i_vertex_a_y, i_vertex_b_x, i_vertex_b_y,
                 i_vertex_c_x, i_vertex_c_y} <= t;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // The input transaction completes at the rising edge; remember it so the
    // driver knows at the next falling edge whether the payload was taken.
    always @(posedge i_clk) begin
        o_ready_sampled <= i_valid && o_ready && i_rst_n;
        if (i_rst_n && i_valid && o_ready) begin
            expected_centers.insert(expected_centers.size(), circumcenter(
                {i_vertex_a_x, i_vertex_a_y, i_vertex_b_x, i_vertex_b_y,
                 i_vertex_c_x, i_vertex_c_y}));
        end
    end

    // Receiver backpressure, with a long hold-off counted here.
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            recv_hold <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: compares each center transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_center got, want;
            got = '{o_center_x, o_center_y, o_degenerate, o_saturated};
            if (expected_centers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected center: x=%0d y=%0d deg=%0b sat=%0b",
                             got.cx, got.cy, got.deg, got.sat);
            end else begin
                want = expected_centers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("Center mismatch: expected x=%0d y=%0d deg=%0b sat=%0b,",
                               want.cx, want.cy, want.deg, want.sat);
                        $display(" got x=%0d y=%0d deg=%0b sat=%0b",
                                 got.cx, got.cy, got.deg, got.sat);
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int mn, mx;
        mn = -(1 << (CW - 1));
        mx = (1 << (CW - 1)) - 1;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: all-equal and collinear (degenerate), extremes of the
        // range, a unit right triangle, and a near-collinear sliver that
        // drives the center out of range and saturates.
        queue_tri(0, 0, 0, 0, 0, 0);
        queue_tri(mn, mn, mn, mn, mn, mn);
        queue_tri(0, 0, 65536, 65536, mx, mx);
        queue_tri(mn, 0, 0, 0, mx, 0);
        queue_tri(0, 0, 65536, 0, 0, 65536);
        queue_tri(mn, mn, mx, mn, mn, mx);
        queue_tri(mx, mx, mn, mx, mx, mn);
        queue_tri(mn, mn, mx, mx, mn, mx);
        queue_tri(0, 0, mx, 0, mn, 1);
        queue_tri(0, 0, mx, 1, mn, 0);
        queue_tri(mn, mn, mx, mx, mx, mx - 1);
        queue_tri(mn, mx, mx, mn, 0, 1);
        queue_tri(1, 0, 0, 1, -1, 0);
        queue_tri(-1, -1, 1, -1, 0, 1);
        queue_tri(mx, 0, 0, mx, mn, 0);
        queue_tri(mn, 0, 0, mn, mx, 0);
        wait_drained();

        // Pause the sender until all results are in, then hold the receiver
        // off long enough for the pipeline to fill and stall the input.
        repeat (PIPE_LAT + 5) @(posedge i_clk);
        hold_reqs = hold_reqs + 1;
        for (int i = 0; i < 100; i++)
            queue_tri(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 33 : 0;
            for (int i = 0; i < 550; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    // Collinear: the first two vertices coincide.
                    int ax, ay;
                    ax = rand_coord(); ay = rand_coord();
                    queue_tri(ax, ay, ax, ay, rand_coord(), rand_coord());
                end else begin
                    queue_tri(rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord());
                end
            end
            wait_drained();
        end
        repeat (PIPE_LAT + 20) @(posedge i_clk);

        if (mismatches == 0 && expected_centers.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tcc_pkg.sv
rtl/tcc_front.sv
rtl/tcc_div.sv
rtl/triangle_circumcenter.sv
tb/triangle_circumcenter_test.sv
